>>> design/cdre_pkg.sv
// Package for the column dark run extractor: payload structs and limits.
// No dependencies; used by column_dark_run_extractor.
package cdre_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 256;

    localparam logic [7:0] ROW_LAST        = 8'(MAX_ROWS - 1);
    localparam logic [7:0] COLUMN_LAST     = 8'(MAX_COLUMNS - 1);
    localparam logic [7:0] RUN_COUNT_LIMIT = 8'd128;
    localparam logic [7:0] RUN_INDEX_LIMIT = 8'd127;
    localparam logic [7:0] THRESHOLD_RESET = 8'd127;

    typedef struct packed {
        logic [7:0] pixel;
        logic       column_end;
        logic       frame_end;
    } t_pixel_item;

    typedef struct packed {
        logic [7:0] column_index;
        logic [6:0] run_index;
        logic [7:0] first_row;
        logic [7:0] last_row;
        logic [7:0] max_runs;
    } t_run_item;

endpackage

>>> design/column_dark_run_extractor.sv
// Column dark run extractor: one pixel per transfer, one run result when a run closes.
// The closing pixel passes the input register, then the result register holds its run.
// Throughput: one pixel per cycle; the input stalls only while a pixel waits in the input
// register and the result register is full and stalled.
// Reset (synchronous, active low) clears all counters and valids, threshold returns to 127.
// Depends on cdre_pkg.
module column_dark_run_extractor (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cdre_pkg::t_pixel_item i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cdre_pkg::t_run_item   o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_data
);
    import cdre_pkg::*;

    logic [7:0]  r_threshold;
    logic        r_in_valid;
    t_pixel_item r_in_item;
    logic        r_out_valid;
    t_run_item   r_out_item;

    logic [7:0] r_row_count, n_row_count;
    logic [7:0] r_column_count, n_column_count;
    logic       r_in_run, n_in_run;
    logic [7:0] r_run_start_row, n_run_start_row;
    logic [7:0] r_last_dark_row, n_last_dark_row;
    logic [7:0] r_runs_in_column, n_runs_in_column;
    logic [7:0] r_frame_max_runs, n_frame_max_runs;

    logic       advance;
    logic       step;
    logic       dark;
    logic       col_end;
    logic       emit;
    logic [7:0] runs_inc;
    logic [7:0] max_new;
    t_run_item  n_out_item;

    // The work stage moves when the result register is free or being taken.
    assign advance     = !r_out_valid || !i_out_stall;
    assign step        = advance && r_in_valid;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        dark     = r_in_item.pixel <= r_threshold;
        col_end  = r_in_item.column_end || r_in_item.frame_end;
        emit     = (dark && col_end) || (!dark && r_in_run);
        runs_inc = (r_runs_in_column < RUN_COUNT_LIMIT) ? r_runs_in_column + 8'd1
                                                        : r_runs_in_column;
        max_new  = (runs_inc > r_frame_max_runs) ? runs_inc : r_frame_max_runs;

        n_out_item.column_index = r_column_count;
        n_out_item.run_index    = (r_runs_in_column > RUN_INDEX_LIMIT) ? RUN_INDEX_LIMIT[6:0]
                                                                       : r_runs_in_column[6:0];
        // A dark pixel that opens a run also closes it when the column ends here.
        n_out_item.first_row    = (dark && !r_in_run) ? r_row_count : r_run_start_row;
        n_out_item.last_row     = dark ? r_row_count : r_last_dark_row;
        n_out_item.max_runs     = max_new;

        n_in_run         = dark && !col_end;
        n_run_start_row  = (dark && !r_in_run) ? r_row_count : r_run_start_row;
        n_last_dark_row  = dark ? r_row_count : r_last_dark_row;
        n_runs_in_column = col_end ? 8'd0 : (emit ? runs_inc : r_runs_in_column);
        n_row_count      = col_end ? 8'd0
                         : ((r_row_count < ROW_LAST) ? r_row_count + 8'd1 : r_row_count);
        if (r_in_item.frame_end) begin
            n_column_count = 8'd0;
        end else if (col_end && (r_column_count < COLUMN_LAST)) begin
            n_column_count = r_column_count + 8'd1;
        end else begin
            n_column_count = r_column_count;
        end
        n_frame_max_runs = r_in_item.frame_end ? 8'd0
                         : (emit ? max_new : r_frame_max_runs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold      <= THRESHOLD_RESET;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_row_count      <= '0;
            r_column_count   <= '0;
            r_in_run         <= 1'b0;
            r_run_start_row  <= '0;
            r_last_dark_row  <= '0;
            r_runs_in_column <= '0;
            r_frame_max_runs <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_threshold <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= step && emit;
            end
            if (step) begin
                r_row_count      <= n_row_count;
                r_column_count   <= n_column_count;
                r_in_run         <= n_in_run;
                r_run_start_row  <= n_run_start_row;
                r_last_dark_row  <= n_last_dark_row;
                r_runs_in_column <= n_runs_in_column;
                r_frame_max_runs <= n_frame_max_runs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (step && emit) begin
            r_out_item <= n_out_item;
        end
    end

`ifndef SYNTHESIS
    a_runs_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_runs_in_column <= RUN_COUNT_LIMIT)
        else $error("run count exceeds its limit");

    a_open_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_run_start_row <= r_last_dark_row))
        else $error("open run starts below its last dark row");

    a_result_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.first_row <= r_out_item.last_row))
        else $error("result first row is after last row");

    a_result_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.max_runs > {1'b0, r_out_item.run_index}))
        else $error("frame maximum below reported run count");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_item.frame_end) |=>
            (r_column_count == 8'd0 && r_frame_max_runs == 8'd0))
        else $error("frame end did not clear column count and maximum");
`endif

endmodule
